@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed: condition must never hold");

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication violated");

`else

`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/ntcl_pkg.sv @@
// ----------------------------------------------------------------------------
// NTC linearizer package
// Shared widths, curve tables, queue item and status types.
// ----------------------------------------------------------------------------
package ntcl_pkg;

    localparam int AdcW        = 12;
    localparam int TempW       = 16;
    localparam int MvFull      = 3300;
    localparam int ScaledW     = 24;
    localparam int FailLimit   = 31;
    localparam int CurveLen    = 16;
    localparam int CurveIdxW   = 4;
    localparam int CurveMvW    = 12;
    localparam int CurveTempW  = 9;
    localparam int TempQ4W     = CurveTempW + 4;
    localparam int DtQ4W       = CurveTempW + 5;
    localparam int QuotW       = 16;
    localparam int QueueDepth  = 4;
    localparam int QueuePtrW   = 2;
    localparam int AddrW       = 3;
    localparam int DataW       = 32;

    localparam int TablePointsDef  = 16;
    localparam int AdcFullScaleDef = 4095;

    localparam logic RegSensorType = 1'b0;

    localparam logic signed [TempW-1:0] FailValue = {1'b0, {(TempW-1){1'b1}}};
    localparam logic signed [TempW-1:0] SatMax    = {1'b0, {(TempW-1){1'b1}}};
    localparam logic signed [TempW-1:0] SatMin    = {1'b1, {(TempW-1){1'b0}}};

    localparam logic signed [CurveTempW-1:0] CurveTemp [2][CurveLen] = '{
        '{-9'sd55, -9'sd50, -9'sd45, -9'sd40, -9'sd35, -9'sd30, -9'sd10, 9'sd10,
          9'sd40, 9'sd65, 9'sd85, 9'sd110, 9'sd135, 9'sd155, 9'sd155, 9'sd155},
        '{-9'sd55, -9'sd40, -9'sd30, -9'sd20, -9'sd10, 9'sd0, 9'sd10, 9'sd30,
          9'sd40, 9'sd60, 9'sd85, 9'sd110, 9'sd125, 9'sd126, 9'sd127, 9'sd128}
    };

    localparam logic [CurveMvW-1:0] CurveMv [2][CurveLen] = '{
        '{12'd3, 12'd5, 12'd7, 12'd11, 12'd15, 12'd21, 12'd73, 12'd217,
          12'd751, 12'd1550, 12'd2170, 12'd3030, 12'd3480, 12'd3740, 12'd3740, 12'd3740},
        '{12'd13, 12'd39, 12'd71, 12'd122, 12'd197, 12'd303, 12'd450, 12'd877,
          12'd1160, 12'd1810, 12'd2600, 12'd3200, 12'd3450, 12'd3500, 12'd3600, 12'd3700}
    };

    typedef struct packed {
        logic [ScaledW-1:0] scaled;
        logic               fail;
        logic               sel;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

@@ rtl/ntcl_if.sv @@
// ----------------------------------------------------------------------------
// NTC linearizer channels
// Valid/ready channels for ADC sample beats and temperature result beats.
// ----------------------------------------------------------------------------
interface ntcl_in_if import ntcl_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [AdcW-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink (input valid, input adc_sample, output ready);
endinterface

interface ntcl_out_if import ntcl_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [TempW-1:0] temperature_q4;
    logic                    sensor_fail;

    modport source (output valid, output temperature_q4, output sensor_fail, input ready);
    modport sink (input valid, input temperature_q4, input sensor_fail, output ready);
endinterface

@@ rtl/ntcl_front.sv @@
// ----------------------------------------------------------------------------
// NTC linearizer front end
// Takes sample beats, flags faults, scales to millivolt units, feeds queue.
// ----------------------------------------------------------------------------
module ntcl_front import ntcl_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ntcl_in_if.sink       i_sample,
    input  logic          i_sensor_type,
    input  t_q_stat       i_q_stat,
    output logic          o_push,
    output t_item         o_item
);

    logic  r_v;
    t_item r_item;
    logic  w_acc;

    assign o_push         = r_v && !i_q_stat.full;
    assign i_sample.ready = !r_v || !i_q_stat.full;
    assign w_acc          = i_sample.valid && i_sample.ready;
    assign o_item         = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_acc) begin
            r_v <= 1'b1;
        end else if (o_push) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_item.scaled <= ScaledW'(i_sample.adc_sample) * ScaledW'(MvFull);
            r_item.fail   <= i_sample.adc_sample < AdcW'(FailLimit);
            r_item.sel    <= i_sensor_type;
        end
    end

endmodule

@@ rtl/ntcl_queue.sv @@
// ----------------------------------------------------------------------------
// NTC linearizer item queue
// Small FIFO that decouples the front end from the arithmetic back end.
// ----------------------------------------------------------------------------
module ntcl_queue import ntcl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    input  logic    i_pop,
    output t_item   o_item,
    output t_q_stat o_stat
);

    t_item                r_mem [QueueDepth];
    logic [QueuePtrW-1:0] r_wr;
    logic [QueuePtrW-1:0] r_rd;
    logic [QueuePtrW:0]   r_cnt;

    assign o_item       = r_mem[r_rd];
    assign o_stat.full  = r_cnt == (QueuePtrW+1)'(QueueDepth);
    assign o_stat.empty = r_cnt == '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

@@ rtl/ntcl_back.sv @@
// ----------------------------------------------------------------------------
// NTC linearizer back end
// Pipelined segment search, interpolation products and restoring divider.
// ----------------------------------------------------------------------------
module ntcl_back import ntcl_pkg::*; #(
    parameter int TABLE_POINTS   = TablePointsDef,
    parameter int ADC_FULL_SCALE = AdcFullScaleDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_item      i_item,
    input  t_q_stat    i_q_stat,
    output logic       o_pop,
    ntcl_out_if.source o_result
);

    localparam int NPts  = (TABLE_POINTS > CurveLen) ? CurveLen :
                           ((TABLE_POINTS < 2) ? 2 : TABLE_POINTS);
    localparam int Steps = $clog2(NPts - 1);
    localparam int FsW   = $clog2(ADC_FULL_SCALE + 1);
    localparam int MvfsW = CurveMvW + FsW;
    localparam int CmpW  = (MvfsW > ScaledW) ? MvfsW : ScaledW;
    localparam int DiffW = CmpW + 1;
    localparam int P1W   = TempQ4W + MvfsW + 1;
    localparam int P2W   = DtQ4W + DiffW;
    localparam int NumW  = ((P1W > P2W) ? P1W : P2W) + 1;
    localparam int WideW = (NumW > MvfsW + QuotW) ? NumW : MvfsW + QuotW;
    localparam int NStg  = Steps + 6 + QuotW;
    localparam logic [CurveIdxW-1:0] IdxTop = CurveIdxW'(NPts - 1);

    typedef struct packed {
        logic                       fail;
        logic                       flat;
        logic                       neg;
        logic                       ovf;
        logic signed [TempQ4W-1:0]  a16;
        logic [MvfsW-1:0]           den;
    } t_dcar;

    logic [NStg-1:0] r_v;
    logic            w_adv;

    // search stages
    t_item                r_s_item [Steps+1];
    logic [CurveIdxW-1:0] r_s_lo   [Steps+1];
    logic [CurveIdxW-1:0] r_s_hi   [Steps+1];

    // segment lookup stage
    logic [CurveIdxW-1:0]         w_hi;
    logic [CurveIdxW-1:0]         w_lo;
    logic                         w_sel;
    logic [CurveMvW-1:0]          w_v0;
    logic [CurveMvW-1:0]          w_v1;
    logic signed [CurveTempW-1:0] w_t0;
    logic signed [CurveTempW-1:0] w_t1;
    logic signed [CurveTempW:0]   w_dt;
    logic [MvfsW-1:0]             w_v0fs;
    logic [MvfsW-1:0]             w_den;
    logic signed [DiffW-1:0]      w_diff;

    logic signed [TempQ4W-1:0] r_l_a16;
    logic signed [DtQ4W-1:0]   r_l_dt16;
    logic signed [DiffW-1:0]   r_l_diff;
    logic [MvfsW-1:0]          r_l_den;
    logic                      r_l_fail;
    logic                      r_l_flat;

    // product stage
    logic signed [P1W-1:0]     r_m_p1;
    logic signed [P2W-1:0]     r_m_p2;
    logic signed [TempQ4W-1:0] r_m_a16;
    logic [MvfsW-1:0]          r_m_den;
    logic                      r_m_fail;
    logic                      r_m_flat;

    // numerator stage
    logic signed [NumW-1:0]    w_num;
    logic [WideW-1:0]          r_n_mag;
    logic                      r_n_neg;
    logic signed [TempQ4W-1:0] r_n_a16;
    logic [MvfsW-1:0]          r_n_den;
    logic                      r_n_fail;
    logic                      r_n_flat;

    // divider stages
    logic [WideW-1:0] r_d_rem [QuotW+1];
    logic [QuotW-1:0] r_d_q   [QuotW+1];
    t_dcar            r_d_car [QuotW+1];

    // result
    logic signed [TempW-1:0] r_o_temp;
    logic                    r_o_fail;
    logic signed [TempW-1:0] n_o_temp;
    logic [QuotW-1:0]        w_qm;
    t_dcar                   w_fc;

    assign w_adv = !r_v[NStg-1] || o_result.ready;
    assign o_pop = w_adv && !i_q_stat.empty;

    assign o_result.valid          = r_v[NStg-1];
    assign o_result.temperature_q4 = r_o_temp;
    assign o_result.sensor_fail    = r_o_fail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[NStg-2:0], o_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s_item[0] <= i_item;
            r_s_lo[0]   <= '0;
            r_s_hi[0]   <= IdxTop;
        end
    end

    for (genvar k = 0; k < Steps; k++) begin : g_search
        logic [CurveIdxW:0]   w_sum;
        logic [CurveIdxW-1:0] w_mid;
        logic                 w_on;
        logic [MvfsW-1:0]     w_thr;
        logic                 w_ge;

        assign w_sum = {1'b0, r_s_lo[k]} + {1'b0, r_s_hi[k]};
        assign w_mid = w_sum[CurveIdxW:1];
        assign w_on  = ({1'b0, r_s_lo[k]} + 1'b1) < {1'b0, r_s_hi[k]};
        assign w_thr = MvfsW'(CurveMv[r_s_item[k].sel][w_mid]) * MvfsW'(ADC_FULL_SCALE);
        assign w_ge  = CmpW'(r_s_item[k].scaled) >= CmpW'(w_thr);

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_s_item[k+1] <= r_s_item[k];
                r_s_lo[k+1]   <= (w_on && w_ge) ? w_mid : r_s_lo[k];
                r_s_hi[k+1]   <= (w_on && !w_ge) ? w_mid : r_s_hi[k];
            end
        end
    end

    assign w_hi   = r_s_hi[Steps];
    assign w_lo   = w_hi - 1'b1;
    assign w_sel  = r_s_item[Steps].sel;
    assign w_v0   = CurveMv[w_sel][w_lo];
    assign w_v1   = CurveMv[w_sel][w_hi];
    assign w_t0   = CurveTemp[w_sel][w_lo];
    assign w_t1   = CurveTemp[w_sel][w_hi];
    assign w_dt   = $signed({w_t1[CurveTempW-1], w_t1}) - $signed({w_t0[CurveTempW-1], w_t0});
    assign w_v0fs = MvfsW'(w_v0) * MvfsW'(ADC_FULL_SCALE);
    assign w_den  = MvfsW'(w_v1 - w_v0) * MvfsW'(ADC_FULL_SCALE);
    assign w_diff = $signed({1'b0, CmpW'(r_s_item[Steps].scaled)})
                  - $signed({1'b0, CmpW'(w_v0fs)});

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_l_a16  <= $signed({w_t0, 4'b0000});
            r_l_dt16 <= $signed({w_dt, 4'b0000});
            r_l_diff <= w_diff;
            r_l_den  <= w_den;
            r_l_fail <= r_s_item[Steps].fail;
            r_l_flat <= w_v1 == w_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m_p1   <= r_l_a16 * $signed({1'b0, r_l_den});
            r_m_p2   <= r_l_dt16 * r_l_diff;
            r_m_a16  <= r_l_a16;
            r_m_den  <= r_l_den;
            r_m_fail <= r_l_fail;
            r_m_flat <= r_l_flat;
        end
    end

    assign w_num = NumW'(r_m_p1) + NumW'(r_m_p2);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_n_neg  <= w_num[NumW-1];
            r_n_mag  <= WideW'($unsigned(w_num[NumW-1] ? -w_num : w_num));
            r_n_a16  <= r_m_a16;
            r_n_den  <= r_m_den;
            r_n_fail <= r_m_fail;
            r_n_flat <= r_m_flat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d_rem[0]      <= r_n_mag;
            r_d_q[0]        <= '0;
            r_d_car[0].fail <= r_n_fail;
            r_d_car[0].flat <= r_n_flat;
            r_d_car[0].neg  <= r_n_neg;
            r_d_car[0].ovf  <= (r_n_mag >> QuotW) >= WideW'(r_n_den);
            r_d_car[0].a16  <= r_n_a16;
            r_d_car[0].den  <= r_n_den;
        end
    end

    for (genvar k = 0; k < QuotW; k++) begin : g_div
        localparam int Sh = QuotW - 1 - k;
        logic [WideW-1:0] w_sub;
        logic             w_ge;

        assign w_sub = WideW'(r_d_car[k].den) << Sh;
        assign w_ge  = r_d_rem[k] >= w_sub;

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_d_rem[k+1] <= w_ge ? r_d_rem[k] - w_sub : r_d_rem[k];
                r_d_q[k+1]   <= {r_d_q[k][QuotW-2:0], w_ge};
                r_d_car[k+1] <= r_d_car[k];
            end
        end
    end

    assign w_qm = r_d_q[QuotW];
    assign w_fc = r_d_car[QuotW];

    always_comb begin
        n_o_temp = TempW'(w_qm);
        if (w_fc.fail) begin
            n_o_temp = FailValue;
        end else if (w_fc.flat) begin
            n_o_temp = TempW'(w_fc.a16);
        end else if (w_fc.neg) begin
            if (w_fc.ovf || (w_qm > QuotW'($unsigned(SatMin)))) begin
                n_o_temp = SatMin;
            end else begin
                n_o_temp = $signed(TempW'(~w_qm + 1'b1));
            end
        end else if (w_fc.ovf || (w_qm > QuotW'($unsigned(SatMax)))) begin
            n_o_temp = SatMax;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_temp <= n_o_temp;
            r_o_fail <= w_fc.fail;
        end
    end

endmodule

@@ rtl/ntc_thermistor_linearizer_unit.sv @@
// Throughput: one sample beat per cycle while o_result is ready, set by the fully
//   pipelined 4-step segment search and the 16-stage restoring divider.
// Reset: synchronous active low; clears all valid flags and queue pointers,
//   and selects sensor curve 0.
// ----------------------------------------------------------------------------
// NTC thermistor linearizer
// Converts ADC samples to Q12.4 temperature through curve table interpolation.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ntc_thermistor_linearizer_unit import ntcl_pkg::*; #(
    parameter int TABLE_POINTS   = TablePointsDef,
    parameter int ADC_FULL_SCALE = AdcFullScaleDef
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    ntcl_in_if.sink          i_sample,
    ntcl_out_if.source       o_result
);

    logic    r_sensor_type;
    logic    w_wr;
    logic    w_push;
    logic    w_pop;
    t_item   w_f_item;
    t_item   w_q_item;
    t_q_stat w_q_stat;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready && (paddr[AddrW-1] == RegSensorType);
    assign prdata = (paddr[AddrW-1] == RegSensorType) ? DataW'(r_sensor_type) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_type <= 1'b0;
        end else if (w_wr) begin
            r_sensor_type <= pwdata[0];
        end
    end

    ntcl_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_sample      (i_sample),
        .i_sensor_type (r_sensor_type),
        .i_q_stat      (w_q_stat),
        .o_push        (w_push),
        .o_item        (w_f_item)
    );

    ntcl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_f_item),
        .i_pop   (w_pop),
        .o_item  (w_q_item),
        .o_stat  (w_q_stat)
    );

    ntcl_back #(
        .TABLE_POINTS   (TABLE_POINTS),
        .ADC_FULL_SCALE (ADC_FULL_SCALE)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (w_q_item),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_result (o_result)
    );

    `ASSERT_NEVER(a_q_overrun, i_clk, i_rst_n, w_push && w_q_stat.full)
    `ASSERT_NEVER(a_q_underrun, i_clk, i_rst_n, w_pop && w_q_stat.empty)
    `ASSERT_IMPLY(a_fail_value, i_clk, i_rst_n, o_result.valid && o_result.sensor_fail, o_result.temperature_q4 == FailValue)
    `ASSERT_NEXT(a_cfg_write, i_clk, i_rst_n, w_wr, r_sensor_type == $past(pwdata[0]))

endmodule
